>>> hdl/mpct_pkg.sv
// Shared types and codes for the multichannel periodic compare timer.
// Holds the request/response payload structs, the controller-datapath interface
// and the opcode, event and channel-mode codes. Depends on nothing.
package mpct_pkg;

   // default geometry
   localparam int CHANNELS_DEF = 4;
   localparam int LF_FIRST_DEF = 1;

   // request kinds
   localparam logic [2:0] KIND_HF_TICK  = 3'd0;
   localparam logic [2:0] KIND_LF_TICK  = 3'd1;
   localparam logic [2:0] KIND_SCHEDULE = 3'd2;
   localparam logic [2:0] KIND_STOP     = 3'd3;
   localparam logic [2:0] KIND_WAIT_CAP = 3'd4;
   localparam logic [2:0] KIND_CAPTURE  = 3'd5;
   localparam logic [2:0] KIND_QUERY    = 3'd6;

   // response kinds
   localparam logic [1:0] EV_EXPIRED  = 2'd0;
   localparam logic [1:0] EV_CAPTURED = 2'd1;
   localparam logic [1:0] EV_QUERY    = 2'd2;

   // channel modes
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_ARMED = 2'd1,
      MODE_WAIT  = 2'd2
   } mode_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FLUSH
   } ctrl_state_type;

   // input item
   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  channel;
      logic [63:0] start_time;
      logic [63:0] period;
      logic        has_handler;
   } req_type;

   // result item
   typedef struct packed {
      logic [1:0]  event_kind;
      logic [1:0]  event_channel;
      logic [63:0] time_value;
      logic        is_scheduled;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic execute;
      logic fire;
      logic advance;
      logic flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic exec_scan;
      logic fire_now;
      logic scan_done;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

>>> hdl/mpct_ctrl.sv
// Sequencing controller of the compare timer.
// Steps each item through accept, execute, an optional channel scan and final flush.
// Depends on mpct_pkg.
module mpct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mpct_pkg::status_type   status,
   output mpct_pkg::cmd_type      cmd
);

   mpct_pkg::ctrl_state_type state_ff;
   mpct_pkg::ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mpct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = mpct_pkg::ST_EXEC;
            end
         end
         mpct_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = status.exec_scan ? mpct_pkg::ST_SCAN : mpct_pkg::ST_FLUSH;
         end
         mpct_pkg::ST_SCAN: begin
            // hold while an earlier result still blocks the output register
            if (!(status.fire_now && status.pend_valid && !status.out_free)) begin
               cmd.fire    = status.fire_now;
               cmd.advance = 1'b1;
               if (status.scan_done) begin
                  state_in = mpct_pkg::ST_FLUSH;
               end
            end
         end
         mpct_pkg::ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = mpct_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = mpct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpct_pkg::ST_IDLE;
         end
      endcase
   end

   // commands only in their own states
   a_fire_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> state_ff == mpct_pkg::ST_SCAN && status.fire_now)
      else $error("fire outside scan");
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> status.pend_valid && status.out_free)
      else $error("flush without pending result or free output");
   a_exec_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.execute)
      else $error("accepted item not executed");

endmodule

>>> hdl/mpct_datapath.sv
// Datapath of the compare timer: time counters, channel table, pending result
// and output register. One 64-bit compare and one 64-bit add serve the scan.
// Depends on mpct_pkg.
module mpct_datapath #(
   parameter int CHANNELS = mpct_pkg::CHANNELS_DEF,
   parameter int LF_FIRST = mpct_pkg::LF_FIRST_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mpct_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mpct_pkg::rsp_type      rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_data,
   input  mpct_pkg::cmd_type      cmd,
   output mpct_pkg::status_type   status
);

   localparam int CW = $clog2(CHANNELS);

   mpct_pkg::req_type  req_ff, req_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               hf_en_ff, hf_en_in;
   logic [63:0]        hf_count_ff, hf_count_in;
   logic [63:0]        lf_count_ff, lf_count_in;
   mpct_pkg::mode_type mode_ff [CHANNELS];
   mpct_pkg::mode_type mode_in [CHANNELS];
   logic [63:0]        expire_ff [CHANNELS];
   logic [63:0]        expire_in [CHANNELS];
   logic [63:0]        period_ff [CHANNELS];
   logic [63:0]        period_in [CHANNELS];
   logic               capt_ff [CHANNELS];
   logic               capt_in [CHANNELS];
   logic               pend_valid_ff, pend_valid_in;
   mpct_pkg::rsp_type  pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mpct_pkg::rsp_type  rsp_ff, rsp_in;

   logic [CW+1:0]      chan_ext;
   logic [CW+1:0]      idx_ext;
   logic               ch_ok;
   logic               idx_hf;
   logic [63:0]        cur_clock;
   logic               due;
   logic               match;
   logic               clock_on;
   logic               push;

   // decode of the current table entry
   always_comb begin
      chan_ext  = (CW+2)'(req_data.channel);
      idx_ext   = (CW+2)'(idx_ff);
      ch_ok     = 32'(req_ff.channel) < 32'(CHANNELS);
      idx_hf    = 32'(idx_ff) < 32'(LF_FIRST);
      cur_clock = idx_hf ? hf_count_ff : lf_count_ff;
      due       = cur_clock >= expire_ff[idx_ff];
      clock_on  = !idx_hf || hf_en_ff;
      match     = (req_ff.kind == mpct_pkg::KIND_SCHEDULE) ||
                  (idx_hf == (req_ff.kind == mpct_pkg::KIND_HF_TICK));
   end

   // status to the controller
   always_comb begin
      status.exec_scan  = (req_ff.kind == mpct_pkg::KIND_HF_TICK && hf_en_ff) ||
                          (req_ff.kind == mpct_pkg::KIND_LF_TICK) ||
                          (req_ff.kind == mpct_pkg::KIND_SCHEDULE && ch_ok &&
                           mode_ff[idx_ff] != mpct_pkg::MODE_ARMED);
      status.fire_now   = match && clock_on && due &&
                          mode_ff[idx_ff] == mpct_pkg::MODE_ARMED;
      status.scan_done  = (req_ff.kind == mpct_pkg::KIND_SCHEDULE) ||
                          (idx_ff == CW'(CHANNELS - 1));
      status.pend_valid = pend_valid_ff;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // next values
   always_comb begin
      req_in        = req_ff;
      idx_in        = idx_ff;
      hf_en_in      = hf_en_ff;
      hf_count_in   = hf_count_ff;
      lf_count_in   = lf_count_ff;
      mode_in       = mode_ff;
      expire_in     = expire_ff;
      period_in     = period_ff;
      capt_in       = capt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      push          = 1'b0;

      // configuration write
      if (csr_valid) begin
         hf_en_in = csr_data;
      end

      // latch item, point the table at its channel (channel 0 for ticks)
      if (cmd.accept) begin
         req_in = req_data;
         if (req_data.kind == mpct_pkg::KIND_HF_TICK ||
             req_data.kind == mpct_pkg::KIND_LF_TICK) begin
            idx_in = '0;
         end else begin
            idx_in = chan_ext[CW-1:0];
         end
      end

      // one operation per item
      if (cmd.execute) begin
         unique case (req_ff.kind)
            mpct_pkg::KIND_HF_TICK: begin
               if (hf_en_ff) begin
                  hf_count_in = hf_count_ff + 64'd1;
               end
            end
            mpct_pkg::KIND_LF_TICK: begin
               lf_count_in = lf_count_ff + 64'd1;
            end
            mpct_pkg::KIND_SCHEDULE: begin
               if (ch_ok && mode_ff[idx_ff] != mpct_pkg::MODE_ARMED) begin
                  period_in[idx_ff] = req_ff.period;
                  expire_in[idx_ff] = req_ff.start_time + req_ff.period;
                  mode_in[idx_ff]   = mpct_pkg::MODE_ARMED;
                  capt_in[idx_ff]   = 1'b0;
               end
            end
            mpct_pkg::KIND_STOP: begin
               if (ch_ok) begin
                  mode_in[idx_ff] = mpct_pkg::MODE_IDLE;
                  capt_in[idx_ff] = 1'b0;
               end
            end
            mpct_pkg::KIND_WAIT_CAP: begin
               if (ch_ok && mode_ff[idx_ff] != mpct_pkg::MODE_ARMED) begin
                  mode_in[idx_ff] = mpct_pkg::MODE_WAIT;
                  capt_in[idx_ff] = req_ff.has_handler;
               end
            end
            mpct_pkg::KIND_CAPTURE: begin
               if (ch_ok && mode_ff[idx_ff] == mpct_pkg::MODE_WAIT &&
                   capt_ff[idx_ff] && clock_on) begin
                  pend_valid_in         = 1'b1;
                  pend_in.event_kind    = mpct_pkg::EV_CAPTURED;
                  pend_in.event_channel = req_ff.channel;
                  pend_in.time_value    = cur_clock;
                  pend_in.is_scheduled  = 1'b0;
                  pend_in.last          = 1'b0;
               end
            end
            mpct_pkg::KIND_QUERY: begin
               pend_valid_in         = 1'b1;
               pend_in.event_kind    = mpct_pkg::EV_QUERY;
               pend_in.event_channel = req_ff.channel;
               pend_in.time_value    = ch_ok ? expire_ff[idx_ff] : 64'd0;
               pend_in.is_scheduled  = ch_ok && mode_ff[idx_ff] == mpct_pkg::MODE_ARMED;
               pend_in.last          = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // expiry: older pending result moves out, new one waits for its last flag
      if (cmd.fire) begin
         if (pend_valid_ff) begin
            push        = 1'b1;
            rsp_in      = pend_ff;
            rsp_in.last = 1'b0;
         end
         pend_valid_in         = 1'b1;
         pend_in.event_kind    = mpct_pkg::EV_EXPIRED;
         pend_in.event_channel = idx_ext[1:0];
         pend_in.time_value    = expire_ff[idx_ff];
         pend_in.is_scheduled  = 1'b0;
         pend_in.last          = 1'b0;
         if (period_ff[idx_ff] != 64'd0) begin
            expire_in[idx_ff] = expire_ff[idx_ff] + period_ff[idx_ff];
         end else begin
            mode_in[idx_ff] = mpct_pkg::MODE_IDLE;
         end
      end

      if (cmd.advance) begin
         idx_in = idx_ff + 1'b1;
      end

      // final result of the item
      if (cmd.flush) begin
         push          = 1'b1;
         rsp_in        = pend_ff;
         rsp_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end

      // output register
      rsp_valid_in = push || (rsp_valid_ff && !rsp_ready);
   end

   // control state and channel table
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         hf_en_ff      <= 1'b1;
         hf_count_ff   <= 64'd0;
         lf_count_ff   <= 64'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            mode_ff[i]   <= mpct_pkg::MODE_IDLE;
            expire_ff[i] <= 64'd0;
            period_ff[i] <= 64'd0;
            capt_ff[i]   <= 1'b0;
         end
      end else begin
         idx_ff        <= idx_in;
         hf_en_ff      <= hf_en_in;
         hf_count_ff   <= hf_count_in;
         lf_count_ff   <= lf_count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         mode_ff       <= mode_in;
         expire_ff     <= expire_in;
         period_ff     <= period_in;
         capt_ff       <= capt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten");
   // scan stays inside the table
   a_fire_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> 32'(idx_ff) < 32'(CHANNELS))
      else $error("fire beyond table");
   // only query replies report the armed flag
   a_sched_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.event_kind != mpct_pkg::EV_QUERY |-> !rsp_ff.is_scheduled)
      else $error("armed flag on non-query result");
   // flush empties the pending slot
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !pend_valid_ff)
      else $error("pending result kept after flush");

endmodule

>>> hdl/multichannel_periodic_compare_timer_top.sv
// Top level of the multichannel periodic compare timer.
// Joins mpct_ctrl and mpct_datapath. Depends on mpct_pkg.
//
// Usage: items enter on req_* (valid/ready) as tick, schedule, stop,
// wait-capture, capture-edge and query operations; results leave on rsp_*
// (valid/ready), the final one of each item flagged by last. csr_* writes
// hf_enable and is always ready.
// Sequence: one item at a time. Stop, wait-capture and idle ticks go through
// accept, execute and flush; query and capture take the same steps to the
// result. A tick scans the channel table, a schedule only its own channel,
// one channel per cycle unless the output blocks, through a single 64-bit
// compare and add, so a tick may emit up to one expiry per channel.
// Each result waits in a pending slot until the next result or the end of
// the scan sets its last flag, then moves to the output register.
// Stalls: while rsp_ready is low the scan holds at a firing channel and new
// items wait; one result can sit in the output register while the next item
// is accepted.
// Reset: counters, channel table and pending results cleared, hf_enable = 1.
module multichannel_periodic_compare_timer_top #(
   parameter int CHANNELS = mpct_pkg::CHANNELS_DEF,
   parameter int LF_FIRST = mpct_pkg::LF_FIRST_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mpct_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mpct_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data
);

   mpct_pkg::cmd_type    cmd;
   mpct_pkg::status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencer
   mpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // counters, table and result path
   mpct_datapath #(
      .CHANNELS (CHANNELS),
      .LF_FIRST (LF_FIRST)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> verif/multichannel_periodic_compare_timer_top_test.sv
// Self-checking testbench for multichannel_periodic_compare_timer_top: directed and random
// tick, schedule, stop, capture and query items against a cycle-free timer predictor.
// Depends on mpct_pkg and the timer RTL under hdl.
`timescale 1ns / 100ps

module multichannel_periodic_compare_timer_top_test;

   localparam int          HALF_PERIOD   = 6;
   localparam int          RESET_CYCLES  = 5;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          REPORT_LIMIT  = 10;
   localparam longint      TIMEOUT_NS    = 2_000_000;
   localparam logic [2:0]  KIND_UNUSED   = 3'd7;
   localparam logic [63:0] ALL_ONES      = '1;

   // dut ports
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mpct_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mpct_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data  = 1'b0;

   // stimulus and checking state
   mpct_pkg::req_type pending_reqs[$];
   mpct_pkg::rsp_type expected_events[$];
   mpct_pkg::rsp_type step_events[$];
   int                fail_count    = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   logic              hold_toggle   = 1'b0;
   logic              hold_seen     = 1'b0;
   int                hold_left     = 0;

   // timer predictor state
   logic               hf_on;
   logic [63:0]        hf_ticks;
   logic [63:0]        lf_ticks;
   mpct_pkg::mode_type chan_mode[mpct_pkg::CHANNELS_DEF];
   logic [63:0]        chan_expiry[mpct_pkg::CHANNELS_DEF];
   logic [63:0]        chan_period[mpct_pkg::CHANNELS_DEF];
   logic               chan_capture[mpct_pkg::CHANNELS_DEF];

   // generator view of the counters, used to place expiries close to now
   logic [63:0] gen_hf_ticks = '0;
   logic [63:0] gen_lf_ticks = '0;
   logic        gen_hf_on    = 1'b1;

   multichannel_periodic_compare_timer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void clear_timer_model();
      hf_on    = 1'b1;
      hf_ticks = '0;
      lf_ticks = '0;
      for (int c = 0; c < mpct_pkg::CHANNELS_DEF; c++) begin
         chan_mode[c]    = mpct_pkg::MODE_IDLE;
         chan_expiry[c]  = '0;
         chan_period[c]  = '0;
         chan_capture[c] = 1'b0;
      end
   endfunction

   function automatic logic [63:0] count_for(int unsigned ch);
      return (ch < mpct_pkg::LF_FIRST_DEF) ? hf_ticks : lf_ticks;
   endfunction

   // emit an expiry when an armed channel is due, then re-arm or go idle
   function automatic void fire_if_due(int unsigned ch);
      mpct_pkg::rsp_type ev;
      if (chan_mode[ch] != mpct_pkg::MODE_ARMED) return;
      if (ch < mpct_pkg::LF_FIRST_DEF && !hf_on) return;
      if (count_for(ch) < chan_expiry[ch]) return;
      ev               = '0;
      ev.event_kind    = mpct_pkg::EV_EXPIRED;
      ev.event_channel = 2'(ch);
      ev.time_value    = chan_expiry[ch];
      step_events.push_back(ev);
      if (chan_period[ch] != '0) chan_expiry[ch] = chan_expiry[ch] + chan_period[ch];
      else chan_mode[ch] = mpct_pkg::MODE_IDLE;
   endfunction

   function automatic void predict_item(mpct_pkg::req_type item);
      int unsigned       ch;
      logic              in_table;
      mpct_pkg::rsp_type ev;
      ch       = item.channel;
      in_table = ch < mpct_pkg::CHANNELS_DEF;
      ev       = '0;
      step_events.delete();
      case (item.kind)
         mpct_pkg::KIND_HF_TICK: begin
            if (hf_on) begin
               hf_ticks = hf_ticks + 64'd1;
               for (int c = 0; c < mpct_pkg::CHANNELS_DEF; c++)
                  if (c < mpct_pkg::LF_FIRST_DEF) fire_if_due(c);
            end
         end
         mpct_pkg::KIND_LF_TICK: begin
            lf_ticks = lf_ticks + 64'd1;
            for (int c = 0; c < mpct_pkg::CHANNELS_DEF; c++)
               if (c >= mpct_pkg::LF_FIRST_DEF) fire_if_due(c);
         end
         mpct_pkg::KIND_SCHEDULE: begin
            if (in_table && chan_mode[ch] != mpct_pkg::MODE_ARMED) begin
               chan_period[ch]  = item.period;
               chan_expiry[ch]  = item.start_time + item.period;
               chan_mode[ch]    = mpct_pkg::MODE_ARMED;
               chan_capture[ch] = 1'b0;
               fire_if_due(ch);
            end
         end
         mpct_pkg::KIND_STOP: begin
            if (in_table) begin
               chan_mode[ch]    = mpct_pkg::MODE_IDLE;
               chan_capture[ch] = 1'b0;
            end
         end
         mpct_pkg::KIND_WAIT_CAP: begin
            if (in_table && chan_mode[ch] != mpct_pkg::MODE_ARMED) begin
               chan_mode[ch]    = mpct_pkg::MODE_WAIT;
               chan_capture[ch] = item.has_handler;
            end
         end
         mpct_pkg::KIND_CAPTURE: begin
            if (in_table && chan_mode[ch] == mpct_pkg::MODE_WAIT && chan_capture[ch] &&
                !(ch < mpct_pkg::LF_FIRST_DEF && !hf_on)) begin
               ev.event_kind    = mpct_pkg::EV_CAPTURED;
               ev.event_channel = item.channel;
               ev.time_value    = count_for(ch);
               step_events.push_back(ev);
            end
         end
         mpct_pkg::KIND_QUERY: begin
            ev.event_kind    = mpct_pkg::EV_QUERY;
            ev.event_channel = item.channel;
            if (in_table) begin
               ev.time_value   = chan_expiry[ch];
               ev.is_scheduled = chan_mode[ch] == mpct_pkg::MODE_ARMED;
            end
            step_events.push_back(ev);
         end
         default: ;
      endcase
      if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void report_failure(string what, mpct_pkg::rsp_type want,
                                          mpct_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $write("%s: expected kind %0d ch %0d time %h sched %0b last %0b, ",
                what, want.event_kind, want.event_channel, want.time_value,
                want.is_scheduled, want.last);
         $display("got kind %0d ch %0d time %h sched %0b last %0b",
                  got.event_kind, got.event_channel, got.time_value,
                  got.is_scheduled, got.last);
      end
   endfunction

   function automatic void check_event(mpct_pkg::rsp_type got);
      mpct_pkg::rsp_type want;
      if (expected_events.size() == 0) begin
         report_failure("unexpected result", '0, got);
      end else begin
         want = expected_events.pop_front();
         if (got.event_kind !== want.event_kind || got.event_channel !== want.event_channel ||
             got.time_value !== want.time_value || got.is_scheduled !== want.is_scheduled ||
             got.last !== want.last)
            report_failure("result mismatch", want, got);
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_timer_model();
      end else begin
         if (req_valid && req_ready) predict_item(req_data);
         // offer the next item unless the current one is still waiting
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= hold_toggle;
      end else begin
         if (rsp_valid && rsp_ready) check_event(rsp_data);
         // long hold-off on request, otherwise random stalls
         if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(99) >= recv_idle_pct;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_item(input logic [2:0] kind, input logic [1:0] ch,
                             input logic [63:0] start, input logic [63:0] per,
                             input logic handler);
      mpct_pkg::req_type item;
      item.kind        = kind;
      item.channel     = ch;
      item.start_time  = start;
      item.period      = per;
      item.has_handler = handler;
      pending_reqs.push_back(item);
      if (kind == mpct_pkg::KIND_HF_TICK && gen_hf_on) gen_hf_ticks = gen_hf_ticks + 64'd1;
      if (kind == mpct_pkg::KIND_LF_TICK) gen_lf_ticks = gen_lf_ticks + 64'd1;
   endtask

   // mostly well-formed operations near the current time, some raw noise
   task automatic queue_random_item();
      logic [2:0]  kind;
      logic [1:0]  ch;
      logic [63:0] start;
      logic [63:0] per;
      logic [63:0] now;
      int          pick;
      int          per_pick;
      kind     = 3'($urandom);
      ch       = 2'($urandom);
      start    = {$urandom, $urandom};
      per      = {$urandom, $urandom};
      pick     = $urandom_range(99);
      per_pick = $urandom_range(9);
      now      = (ch < mpct_pkg::LF_FIRST_DEF) ? gen_hf_ticks : gen_lf_ticks;
      if (pick < 22) kind = mpct_pkg::KIND_HF_TICK;
      else if (pick < 44) kind = mpct_pkg::KIND_LF_TICK;
      else if (pick < 62) begin
         kind = mpct_pkg::KIND_SCHEDULE;
         if ($urandom_range(7) != 0) start = now + 64'($urandom_range(8)) - 64'd5;
         if (per_pick < 3) per = '0;
         else if (per_pick < 8) per = 64'($urandom_range(4, 1));
         else if (per_pick == 8) per = ALL_ONES - 64'($urandom_range(3));
      end
      else if (pick < 70) kind = mpct_pkg::KIND_STOP;
      else if (pick < 78) kind = mpct_pkg::KIND_WAIT_CAP;
      else if (pick < 86) kind = mpct_pkg::KIND_CAPTURE;
      else if (pick < 94) kind = mpct_pkg::KIND_QUERY;
      queue_item(kind, ch, start, per, 1'($urandom));
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) queue_random_item();
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // wait for every item and result, then let a started tick scan finish;
   // the check runs once the edge's updates have settled
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // called while the block is idle
   task automatic write_hf_enable(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      hf_on     = value;
      gen_hf_on = value;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_hf_enable(1'b1);
      set_idling(19, 86);

      // directed: extremes, every operation, wrap and multi-fire cases
      // reset state, then ticks with nothing armed
      queue_item(mpct_pkg::KIND_QUERY,    2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_HF_TICK,  2'd0, ALL_ONES, ALL_ONES, 1'b1);
      queue_item(mpct_pkg::KIND_LF_TICK,  2'd3, ALL_ONES, ALL_ONES, 1'b1);
      // past expiry one-shot, past expiry periodic, already armed
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd1, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd0, '0, 64'd1, 1'b0);
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd0, 64'd5, 64'd5, 1'b1);
      queue_item(mpct_pkg::KIND_HF_TICK,  2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_QUERY,    2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_STOP,     2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_QUERY,    2'd0, '0, '0, 1'b0);
      // captured, then no handler
      queue_item(mpct_pkg::KIND_WAIT_CAP, 2'd2, '0, '0, 1'b1);
      queue_item(mpct_pkg::KIND_CAPTURE,  2'd2, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_WAIT_CAP, 2'd3, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_CAPTURE,  2'd3, '0, '0, 1'b1);
      // far future after wrap, wait capture while armed is ignored
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd3, ALL_ONES, ALL_ONES, 1'b0);
      queue_item(mpct_pkg::KIND_WAIT_CAP, 2'd3, '0, '0, 1'b1);
      queue_item(mpct_pkg::KIND_QUERY,    2'd3, '0, '0, 1'b0);
      // sum wraps to a near expiry
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd2, ALL_ONES, 64'd3, 1'b0);
      queue_item(mpct_pkg::KIND_STOP,     2'd3, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd1, '0, 64'd2, 1'b0);
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd3, 64'd1, 64'd1, 1'b0);
      // several channels fire, capture while not waiting, unused kind
      queue_item(mpct_pkg::KIND_LF_TICK,  2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_CAPTURE,  2'd1, '0, '0, 1'b1);
      queue_item(KIND_UNUSED,             2'd2, ALL_ONES, ALL_ONES, 1'b1);
      queue_item(mpct_pkg::KIND_QUERY,    2'd2, '0, '0, 1'b0);
      wait_idle();

      queue_random(60);
      wait_idle();

      // high-rate clock disabled: capture blocked, tick ignored, no fire at once
      write_hf_enable(1'b0);
      set_idling(86, 19);
      queue_item(mpct_pkg::KIND_STOP,     2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_WAIT_CAP, 2'd0, '0, '0, 1'b1);
      queue_item(mpct_pkg::KIND_CAPTURE,  2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_HF_TICK,  2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_SCHEDULE, 2'd0, '0, '0, 1'b0);
      queue_item(mpct_pkg::KIND_QUERY,    2'd0, '0, '0, 1'b0);
      queue_random(40);
      wait_idle();

      // re-enabled: long receiver hold-off while items keep coming
      write_hf_enable(1'b1);
      set_idling(0, 0);
      queue_item(mpct_pkg::KIND_HF_TICK, 2'd0, '0, '0, 1'b0);
      hold_toggle <= ~hold_toggle;
      for (int i = 0; i < 30; i++)
         queue_item(mpct_pkg::KIND_QUERY, 2'($urandom), {$urandom, $urandom},
                    {$urandom, $urandom}, 1'($urandom));
      wait_idle();

      set_idling(86, 19);
      queue_random(60);
      wait_idle();

      write_hf_enable(1'b0);
      set_idling(19, 86);
      queue_random(30);
      wait_idle();

      write_hf_enable(1'b1);
      set_idling(0, 0);
      queue_random(40);
      wait_idle();

      if (fail_count == 0 && expected_events.size() == 0) begin
         $display("multichannel_periodic_compare_timer_top_test passed");
      end else begin
         $display("multichannel_periodic_compare_timer_top_test failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("multichannel_periodic_compare_timer_top_test failed");
      $finish;
   end

endmodule

>>> sim.f
hdl/mpct_pkg.sv
hdl/mpct_ctrl.sv
hdl/mpct_datapath.sv
hdl/multichannel_periodic_compare_timer_top.sv
verif/multichannel_periodic_compare_timer_top_test.sv
